// ===== hdl/pli_pkg.sv =====
package pli_pkg;

    // Default list capacity.
    localparam int CAPACITY_DEF = 128;

    // Operation codes carried in the func field.
    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Shift command broadcast from the control logic to every cell.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_shift_cmd;

endpackage

// ===== hdl/pli_if.sv =====
// Request channel: one operation word.
interface pli_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [7:0]         position;
    logic signed [31:0] value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

// Response channel: one result word.
interface pli_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [7:0]         list_length;

    modport source (output valid, status, removed_value, list_length, input ready);
    modport sink   (input valid, status, removed_value, list_length, output ready);
endinterface

// ===== hdl/pli_cell.sv =====
module pli_cell
    import pli_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int SLOT_W   = 9
) (
    input  logic               i_clk,
    input  t_shift_cmd         i_cmd,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    output logic signed [31:0] o_data,
    output logic signed [31:0] o_tap
);

    localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(CELL_IDX + 1);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic [SLOT_W-1:0]  w_pos;
    logic               w_at;
    logic               w_after;

    // Compare the broadcast position with this cell's own one-based slot.
    assign w_pos   = SLOT_W'(i_cmd.position);
    assign w_at    = (w_pos == SLOT);
    assign w_after = (SLOT > w_pos);

    // An insert pushes entries up from the target; a delete pulls them down.
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (w_at) begin
                n_data = i_cmd.value;
            end else if (w_after) begin
                n_data = i_left;
            end
        end else if (i_cmd.del) begin
            if (w_at || w_after) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // The entry at the target slot, zero elsewhere, for the removed-word gather.
    assign o_tap  = w_at ? r_data : 32'sd0;

endmodule

// ===== hdl/positional_list_insert_delete.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells,
// one entry per cell. Each request word names an insert or a delete at a
// one-based position; every cell compares that position with its own slot and
// shifts in the same cycle, so one operation completes per clock unless the output
// register is held, and its result word appears in the cycle after acceptance. A
// new request is taken whenever the output register is empty or being read.
// Exactly one result word is returned per request. Reset empties the list at
// once; the entries themselves are not cleared, since only slots below the
// count are ever read. If CAPACITY exceeds 255 the list length reports the
// low eight bits of the count, and positions above 255 cannot be named.
module positional_list_insert_delete
    import pli_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pli_req_if.sink   i_req,
    pli_rsp_if.source o_rsp
);

    localparam int CNTW  = $clog2(CAPACITY + 1);
    localparam int MW    = ((CNTW > 8) ? CNTW : 8) + 1;
    localparam int LW    = (CNTW > 8) ? CNTW : 8;
    localparam logic [CNTW-1:0] CAP_CNT = CNTW'(CAPACITY);

    logic [CNTW-1:0]    r_count;
    logic [CNTW-1:0]    n_count;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic signed [31:0] r_removed;
    logic [LW-1:0]      w_len_ext;

    logic               w_accept;
    logic               w_is_del;
    logic [MW-1:0]      w_pos;
    logic [MW-1:0]      w_cnt;
    logic               w_ins_bad;
    logic               w_del_bad;
    logic               w_full;
    logic               w_ins_ok;
    logic               w_del_ok;
    t_status            w_status;
    t_shift_cmd         w_cmd;
    logic signed [31:0] w_removed;

    logic signed [31:0] w_data [CAPACITY];
    logic signed [31:0] w_tap  [CAPACITY];

    // Handshake: take a request when the result register is free or draining.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Range checks on the requested position.
    assign w_is_del  = (i_req.func == FUNC_DELETE);
    assign w_pos     = MW'(i_req.position);
    assign w_cnt     = MW'(r_count);
    assign w_ins_bad = (i_req.position == 8'd0) || (w_pos > (w_cnt + MW'(1)));
    assign w_del_bad = (i_req.position == 8'd0) || (w_pos > w_cnt);
    assign w_full    = (r_count == CAP_CNT);
    assign w_ins_ok  = w_accept && !w_is_del && !w_ins_bad && !w_full;
    assign w_del_ok  = w_accept && w_is_del && !w_del_bad;

    always_comb begin
        if (w_is_del) begin
            w_status = w_del_bad ? ST_BADPOS : ST_DONE;
        end else if (w_ins_bad) begin
            w_status = ST_BADPOS;
        end else if (w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_DONE;
        end
    end

    // Command broadcast to the cell row.
    assign w_cmd.ins      = w_ins_ok;
    assign w_cmd.del      = w_del_ok;
    assign w_cmd.position = i_req.position;
    assign w_cmd.value    = i_req.value;

    // The row of cells; the ends take their own word as the missing neighbour.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        pli_cell #(
            .CELL_IDX (g),
            .SLOT_W   (MW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    // Gather the word at the target slot; at most one cell drives a non-zero tap.
    always_comb begin
        w_removed = 32'sd0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_removed = w_removed | w_tap[k];
        end
    end

    // Entry count.
    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CNTW'(1);
        end else if (w_del_ok) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= w_status;
            r_removed <= w_del_ok ? w_removed : 32'sd0;
        end
    end

    assign w_len_ext           = LW'(r_count);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.list_length   = w_len_ext[7:0];

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    // A successful insert grows the list by exactly one entry.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("insert did not grow the list");

    // A full status is only reported while the list is at capacity.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_count == CAP_CNT))
        else $error("full status with room left");

    // A non-zero removed word only comes with a completed operation.
    a_removed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_removed != 32'sd0)) |-> (r_status == ST_DONE))
        else $error("removed word on a failed operation");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pli_pkg::*;

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int RANDOM_OPS   = 1800;
    localparam int QUIET_TAIL   = 250;
    localparam int LONG_HOLD    = 120;
    localparam int HOLD_AT_WORD = 400;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        t_func              func;
        logic [7:0]         position;
        logic signed [31:0] value;
        bit                 drain_first;
    } t_pending_op;

    typedef struct {
        t_status            status;
        logic signed [31:0] removed;
        logic [7:0]         list_len;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pli_req_if req_bus ();
    pli_rsp_if rsp_bus ();

    positional_list_insert_delete #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always #2 i_clk = ~i_clk;

    // Operations waiting to be sent, and results waiting to be seen.
    t_pending_op  pending_ops[$];
    t_list_result expected_results[$];

    // Our own copy of the list, updated as each request word is accepted.
    logic signed [31:0] list_model[LIST_CAP];
    int                 list_count = 0;

    // Entry count as the stimulus generator sees it, used to aim positions.
    int gen_count = 0;

    int mismatch_count = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int gap_left       = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int stalled_cycles = 0;

    // Applies one operation to the model list and returns the expected result.
    function automatic t_list_result apply_list_op(t_func f, logic [7:0] pos,
                                                   logic signed [31:0] val);
        t_list_result res;
        int p;
        p = int'(pos);
        res.status  = ST_DONE;
        res.removed = '0;
        if (f == FUNC_INSERT) begin
            if (p < 1 || p > list_count + 1) begin
                res.status = ST_BADPOS;
            end else if (list_count >= LIST_CAP) begin
                res.status = ST_FULL;
            end else begin
                for (int k = list_count; k >= p; k--) list_model[k] = list_model[k - 1];
                list_model[p - 1] = val;
                list_count++;
            end
        end else begin
            if (p < 1 || p > list_count) begin
                res.status = ST_BADPOS;
            end else begin
                res.removed = list_model[p - 1];
                for (int k = p - 1; k + 1 < list_count; k++) list_model[k] = list_model[k + 1];
                list_count--;
            end
        end
        res.list_len = 8'(list_count);
        return res;
    endfunction

    // Idle rate moves through none, light and heavy as the run goes on.
    function automatic bit take_break(int n);
        case ((n / 150) % 3)
            0: return 1'b0;
            1: return $urandom_range(0, 15) == 0;
            default: return $urandom_range(0, 3) == 0;
        endcase
    endfunction

    // Positions lean towards the two ends of the valid range.
    function automatic int pick_in(int lo, int hi);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 15))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(t_func f, int pos, logic signed [31:0] val, bit drain = 1'b0);
        t_pending_op op;
        op.func        = f;
        op.position    = pos[7:0];
        op.value       = val;
        op.drain_first = drain;
        pending_ops.push_back(op);
        if (f == FUNC_INSERT) begin
            if (pos >= 1 && pos <= gen_count + 1 && gen_count < LIST_CAP) gen_count++;
        end else if (pos >= 1 && pos <= gen_count) begin
            gen_count--;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d (result word %0d, %0t)",
                 what, got, want, results_seen, $realtime);
        mismatch_count++;
    endtask

    // Request driver: takes the next pending operation when the channel is free and no gap or drain wait holds it.
    always @(posedge i_clk) begin
        t_pending_op op;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_results.push_back(apply_list_op(t_func'(req_bus.func),
                                                         req_bus.position, req_bus.value));
                words_sent++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end else if (pending_ops.size() == 0 ||
                             (pending_ops[0].drain_first && expected_results.size() != 0)) begin
                    req_bus.valid <= 1'b0;
                end else if (pending_ops.size() > QUIET_TAIL && take_break(words_sent)) begin
                    gap_left = $urandom_range(0, 9);
                    req_bus.valid <= 1'b0;
                end else begin
                    op = pending_ops.pop_front();
                    req_bus.valid    <= 1'b1;
                    req_bus.func     <= op.func;
                    req_bus.position <= op.position;
                    req_bus.value    <= op.value;
                end
            end
        end
    end

    // Result monitor: checks every accepted result word and paces the ready line.
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("word with nothing expected", rsp_bus.list_length, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", rsp_bus.status, want.status);
                    if (rsp_bus.removed_value !== want.removed)
                        report_mismatch("removed_value", rsp_bus.removed_value, want.removed);
                    if (rsp_bus.list_length !== want.list_len)
                        report_mismatch("list_length", rsp_bus.list_length, want.list_len);
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= HOLD_AT_WORD) begin
                // One long hold-off so the output register fills and the input stalls.
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_bus.ready <= 1'b0;
            end else if (pending_ops.size() > QUIET_TAIL && take_break(results_seen + 75)) begin
                hold_left = $urandom_range(0, 9);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
                if (stalled_cycles >= STALL_LIMIT) begin
                    $display("timeout after %0d idle cycles", stalled_cycles);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int seg;
        int len;
        bit ins;
        req_bus.valid    = 1'b0;
        req_bus.func     = FUNC_INSERT;
        req_bus.position = '0;
        req_bus.value    = '0;
        rsp_bus.ready    = 1'b0;

        // Directed part: empty list, both ends, bad positions, extreme values.
        queue_op(FUNC_DELETE, 1, 32'sd0);
        queue_op(FUNC_DELETE, 0, 32'sd0);
        queue_op(FUNC_INSERT, 0, 32'sd5);
        queue_op(FUNC_INSERT, 2, 32'sd6);
        queue_op(FUNC_INSERT, 1, 32'sh7fff_ffff);
        queue_op(FUNC_INSERT, 1, 32'sh8000_0000);
        queue_op(FUNC_INSERT, 3, -32'sd1);
        queue_op(FUNC_INSERT, 2, 32'sd0);
        queue_op(FUNC_INSERT, 255, 32'sha5a5_a5a5);
        queue_op(FUNC_INSERT, 6, 32'sd7);
        queue_op(FUNC_INSERT, 5, 32'sh5a5a_5a5a);
        queue_op(FUNC_DELETE, 6, 32'sd0);
        queue_op(FUNC_DELETE, 255, 32'sd0);
        queue_op(FUNC_DELETE, 0, 32'sd0);
        // The sender waits here until every earlier result has come back.
        queue_op(FUNC_DELETE, 3, 32'sd0, 1'b1);
        queue_op(FUNC_DELETE, 1, 32'sd0);
        queue_op(FUNC_DELETE, 3, 32'sd0);
        queue_op(FUNC_DELETE, 1, 32'sh1234_5678);
        queue_op(FUNC_INSERT, 128, 32'sd9);
        queue_op(FUNC_DELETE, 1, 32'sd0);
        queue_op(FUNC_DELETE, 1, 32'sd0);

        // Random part, built from segments of well-formed traffic with some noise.
        len = pending_ops.size() + RANDOM_OPS;
        seg = 0;
        while (pending_ops.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // Fill to capacity, knock on a full list, then drain part way.
                    queue_op(FUNC_INSERT, pick_in(1, gen_count + 1), rand_value(),
                             seg == 1 || $urandom_range(0, 5) == 0);
                    while (gen_count < LIST_CAP)
                        queue_op(FUNC_INSERT, pick_in(1, gen_count + 1), rand_value());
                    queue_op(FUNC_INSERT, pick_in(1, gen_count + 1), rand_value());
                    queue_op(FUNC_INSERT, gen_count + 1, rand_value());
                    queue_op(FUNC_INSERT, 0, rand_value());
                    queue_op(FUNC_INSERT, $urandom_range(gen_count + 2, 255), rand_value());
                    len = len + 0;
                    seg = $urandom_range(0, LIST_CAP / 2);
                    while (gen_count > seg)
                        queue_op(FUNC_DELETE, pick_in(1, gen_count), rand_value());
                end
                2: begin
                    // Drain to empty and poke the empty list.
                    while (gen_count > 0)
                        queue_op(FUNC_DELETE, pick_in(1, gen_count), rand_value());
                    queue_op(FUNC_DELETE, 1, rand_value());
                    queue_op(FUNC_INSERT, 2, rand_value());
                end
                default: begin
                    // Random walk over the list with mostly valid positions.
                    repeat ($urandom_range(20, 80)) begin
                        if ($urandom_range(0, 9) == 0) begin
                            queue_op(t_func'($urandom_range(0, 1)), $urandom_range(0, 255),
                                     rand_value(), $urandom_range(0, 40) == 0);
                        end else begin
                            if (gen_count == 0)
                                ins = 1'b1;
                            else if (gen_count == LIST_CAP)
                                ins = $urandom_range(0, 3) == 0;
                            else
                                ins = $urandom_range(0, 99) < 55;
                            if (ins)
                                queue_op(FUNC_INSERT, pick_in(1, gen_count + 1), rand_value());
                            else
                                queue_op(FUNC_DELETE, pick_in(1, gen_count), rand_value());
                        end
                    end
                end
            endcase
            seg++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to be sent and every result to come back.
        do @(posedge i_clk);
        while (pending_ops.size() != 0 || req_bus.valid || expected_results.size() != 0);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
